// ===== sv/tdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Time-of-day clock package
// Command and mode codes, field widths and the wrapping adder shared by the
// time-of-day clock with alarm.
// ----------------------------------------------------------------------------
package tdc_pkg;

    localparam int HourW     = 5;
    localparam int MinW      = 6;
    localparam int TickW     = 16;
    localparam int CmdW      = 3;
    localparam int ModeW     = 3;
    localparam int StepW     = 2;
    localparam int InDataW   = 24;
    localparam int OutDataW  = 56;

    localparam logic [TickW-1:0] TicksPerSecondReset = 16'd1000;
    localparam logic [MinW-1:0]  SecondsPerMinute    = 6'd60;
    localparam logic [MinW-1:0]  MinutesPerHour      = 6'd60;
    localparam logic [HourW-1:0] HoursPerDay         = 5'd24;

    // Command codes.
    localparam logic [CmdW-1:0] CMD_TICK         = 3'd0;
    localparam logic [CmdW-1:0] CMD_BEGIN_TIME   = 3'd1;
    localparam logic [CmdW-1:0] CMD_COMMIT_TIME  = 3'd2;
    localparam logic [CmdW-1:0] CMD_BEGIN_ALARM  = 3'd3;
    localparam logic [CmdW-1:0] CMD_COMMIT_ALARM = 3'd4;
    localparam logic [CmdW-1:0] CMD_ADJUST       = 3'd5;
    localparam logic [CmdW-1:0] CMD_LOAD_ALARM   = 3'd6;

    // Mode codes.
    localparam logic [ModeW-1:0] MODE_NORMAL    = 3'd0;
    localparam logic [ModeW-1:0] MODE_SET_HR    = 3'd1;
    localparam logic [ModeW-1:0] MODE_SET_MN    = 3'd2;
    localparam logic [ModeW-1:0] MODE_SET_AL_HR = 3'd3;
    localparam logic [ModeW-1:0] MODE_SET_AL_MN = 3'd4;

    // Adds a step of -2..1 to a value of 0..63 and wraps it into 0..modulus-1.
    // The biased sum is at most 63 + 1 + modulus, so three conditional subtractions
    // are enough for any modulus of 24 or more.
    function automatic logic [MinW-1:0] wrap_add(
        input logic [MinW-1:0]         value,
        input logic signed [StepW-1:0] delta,
        input logic [MinW-1:0]         modulus
    );
        logic [MinW+1:0] sum;
        sum = {2'b00, value} + {2'b00, modulus}
            + {{(MinW){delta[StepW-1]}}, delta};
        for (int i = 0; i < 3; i++) begin
            if (sum >= {2'b00, modulus}) begin
                sum = sum - {2'b00, modulus};
            end
        end
        return sum[MinW-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/time_of_day_clock_with_alarm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Time-of-day clock with alarm
// A 24-hour clock with one alarm and edit buffers, driven by one command per
// input request.
//
// Input stream: s_axis_tuser carries the command, s_axis_tdata the mode, step
// and alarm load values. Every accepted request yields exactly one result on
// the output stream, which reports the clock, the alarm, both edit buffers,
// the alarm match and the save request as they stand after that command.
// The command is decoded and applied in the cycle it is accepted; the result
// is registered and shows on m_axis_tvalid in the next cycle. One request is
// taken per cycle as long as the receiver takes results: s_axis_tready is
// high whenever the result register is empty or being emptied, so a stalled
// receiver holds one result and stops input until it is taken.
// cfg_we writes ticks_per_second (tick commands per second); write it only
// while no result is pending.
// The synchronous reset clears the clock, the alarm, the buffers and the
// prescaler, drops m_axis_tvalid and sets ticks_per_second to 1000.
// ----------------------------------------------------------------------------
module time_of_day_clock_with_alarm
    import tdc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration: ticks_per_second.
    input  wire logic                  cfg_we,
    input  wire logic [TickW-1:0]      cfg_wdata,
    // Command stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata, lowest bit up: mode[2:0], step[4:3], load_hour[9:5],
    // load_minute[15:10], load_armed[16], zero fill[23:17].
    input  wire logic [InDataW-1:0]    s_axis_tdata,
    // tuser: command[2:0].
    input  wire logic [CmdW-1:0]       s_axis_tuser,
    // Result stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata, lowest bit up: hour[4:0], minute[10:5], second[16:11],
    // alarm hour[21:17], alarm minute[27:22], armed[28],
    // edit hour[33:29], edit minute[39:34],
    // alarm edit hour[44:40], alarm edit minute[50:45],
    // alarm match[51], save request[52], zero fill[55:53].
    output logic [OutDataW-1:0]        m_axis_tdata
);

    logic [TickW-1:0]  tps_reg;
    logic [TickW-1:0]  prescale_reg,  prescale_next;
    logic [MinW-1:0]   sec_reg,       sec_next;
    logic [MinW-1:0]   min_reg,       min_next;
    logic [HourW-1:0]  hour_reg,      hour_next;
    logic [HourW-1:0]  al_hour_reg,   al_hour_next;
    logic [MinW-1:0]   al_min_reg,    al_min_next;
    logic              armed_reg,     armed_next;
    logic [HourW-1:0]  ed_hour_reg,   ed_hour_next;
    logic [MinW-1:0]   ed_min_reg,    ed_min_next;
    logic [HourW-1:0]  ed_al_hour_reg, ed_al_hour_next;
    logic [MinW-1:0]   ed_al_min_reg,  ed_al_min_next;
    logic              save_next;
    logic              match_next;
    logic              out_valid_reg;
    logic [OutDataW-1:0] out_data_reg;

    logic                    accept;
    logic [CmdW-1:0]         cmd;
    logic [ModeW-1:0]        mode;
    logic signed [StepW-1:0] step;
    logic [HourW-1:0]        load_hour;
    logic [MinW-1:0]         load_min;
    logic                    load_armed;
    logic [TickW:0]          prescale_inc;
    logic                    alarm_sel;
    logic                    hour_sel;
    logic [HourW-1:0]        adj_hour_src;
    logic [MinW-1:0]         adj_min_src;
    logic [MinW-1:0]         adj_hour_res;
    logic [MinW-1:0]         adj_min_res;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign cmd        = s_axis_tuser;
    assign mode       = s_axis_tdata[2:0];
    assign step       = s_axis_tdata[4:3];
    assign load_hour  = s_axis_tdata[9:5];
    assign load_min   = s_axis_tdata[15:10];
    assign load_armed = s_axis_tdata[16];

    assign prescale_inc = {1'b0, prescale_reg} + {{TickW{1'b0}}, 1'b1};

    // Adjust picks the alarm buffer from the alarm-hour mode upward; only the
    // two hour modes touch an hour, every other code adjusts a minute.
    assign alarm_sel    = (mode >= MODE_SET_AL_HR);
    assign hour_sel     = (mode == MODE_SET_HR) || (mode == MODE_SET_AL_HR);
    assign adj_hour_src = alarm_sel ? ed_al_hour_reg : ed_hour_reg;
    assign adj_min_src  = alarm_sel ? ed_al_min_reg : ed_min_reg;
    assign adj_hour_res = wrap_add({1'b0, adj_hour_src}, step, {1'b0, HoursPerDay});
    assign adj_min_res  = wrap_add(adj_min_src, step, MinutesPerHour);

    always_comb begin
        prescale_next   = prescale_reg;
        sec_next        = sec_reg;
        min_next        = min_reg;
        hour_next       = hour_reg;
        al_hour_next    = al_hour_reg;
        al_min_next     = al_min_reg;
        armed_next      = armed_reg;
        ed_hour_next    = ed_hour_reg;
        ed_min_next     = ed_min_reg;
        ed_al_hour_next = ed_al_hour_reg;
        ed_al_min_next  = ed_al_min_reg;
        save_next       = 1'b0;
        unique case (cmd)
            CMD_TICK: begin
                if (mode != MODE_SET_HR && mode != MODE_SET_MN) begin
                    if (prescale_inc >= {1'b0, tps_reg}) begin
                        prescale_next = '0;
                        if (sec_reg + 6'd1 >= SecondsPerMinute) begin
                            sec_next = '0;
                            if (min_reg + 6'd1 >= MinutesPerHour) begin
                                min_next = '0;
                                if (hour_reg + 5'd1 >= HoursPerDay) begin
                                    hour_next = '0;
                                end else begin
                                    hour_next = hour_reg + 5'd1;
                                end
                            end else begin
                                min_next = min_reg + 6'd1;
                            end
                        end else begin
                            sec_next = sec_reg + 6'd1;
                        end
                    end else begin
                        prescale_next = prescale_inc[TickW-1:0];
                    end
                end
            end
            CMD_BEGIN_TIME: begin
                ed_hour_next = hour_reg;
                ed_min_next  = min_reg;
            end
            CMD_COMMIT_TIME: begin
                hour_next = ed_hour_reg;
                min_next  = ed_min_reg;
                sec_next  = '0;
            end
            CMD_BEGIN_ALARM: begin
                ed_al_hour_next = al_hour_reg;
                ed_al_min_next  = al_min_reg;
            end
            CMD_COMMIT_ALARM: begin
                al_hour_next = ed_al_hour_reg;
                al_min_next  = ed_al_min_reg;
                armed_next   = 1'b1;
                save_next    = 1'b1;
            end
            CMD_ADJUST: begin
                if (hour_sel) begin
                    if (alarm_sel) begin
                        ed_al_hour_next = adj_hour_res[HourW-1:0];
                    end else begin
                        ed_hour_next = adj_hour_res[HourW-1:0];
                    end
                end else begin
                    if (alarm_sel) begin
                        ed_al_min_next = adj_min_res;
                    end else begin
                        ed_min_next = adj_min_res;
                    end
                end
            end
            CMD_LOAD_ALARM: begin
                al_hour_next = load_hour;
                al_min_next  = load_min;
                armed_next   = load_armed;
            end
            default: begin
            end
        endcase
        match_next = (hour_next == al_hour_next) && (min_next == al_min_next)
                   && (sec_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg        <= TicksPerSecondReset;
            prescale_reg   <= '0;
            sec_reg        <= '0;
            min_reg        <= '0;
            hour_reg       <= '0;
            al_hour_reg    <= '0;
            al_min_reg     <= '0;
            armed_reg      <= 1'b0;
            ed_hour_reg    <= '0;
            ed_min_reg     <= '0;
            ed_al_hour_reg <= '0;
            ed_al_min_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                tps_reg <= cfg_wdata;
            end
            if (accept) begin
                prescale_reg   <= prescale_next;
                sec_reg        <= sec_next;
                min_reg        <= min_next;
                hour_reg       <= hour_next;
                al_hour_reg    <= al_hour_next;
                al_min_reg     <= al_min_next;
                armed_reg      <= armed_next;
                ed_hour_reg    <= ed_hour_next;
                ed_min_reg     <= ed_min_next;
                ed_al_hour_reg <= ed_al_hour_next;
                ed_al_min_reg  <= ed_al_min_next;
                out_valid_reg  <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= {3'b000, save_next, match_next,
                             ed_al_min_next, ed_al_hour_next,
                             ed_min_next, ed_hour_next, armed_next,
                             al_min_next, al_hour_next,
                             sec_next, min_next, hour_next};
        end
    end

    // A save request always comes with an armed alarm in the same result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg[52] |-> out_data_reg[28])
        else $error("save request without armed alarm");

    // A reported match implies the reported second is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg[51] |-> out_data_reg[16:11] == '0)
        else $error("alarm match with nonzero second");

    // Committing the time edit restarts the seconds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd == CMD_COMMIT_TIME |=> sec_reg == '0)
        else $error("seconds not cleared on time commit");

    // The live clock stays in range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sec_reg < SecondsPerMinute && min_reg < MinutesPerHour
        && hour_reg < HoursPerDay)
        else $error("live clock out of range");

    // A held result stays put while the receiver stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result lost or changed");

endmodule
`default_nettype wire

// ===== sim/tdc_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day clock verification types
// Layouts of the command request and the status result on the two streams,
// plus the step and spare codes that the design package leaves unnamed.
// ----------------------------------------------------------------------------
package tdc_tb_pkg;
    import tdc_pkg::*;

    localparam logic [CmdW-1:0]  CMD_SPARE    = 3'd7;
    localparam logic [ModeW-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [ModeW-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [ModeW-1:0] MODE_SPARE_7 = 3'd7;

    localparam logic [StepW-1:0] STEP_ZERO      = 2'b00;
    localparam logic [StepW-1:0] STEP_PLUS_ONE  = 2'b01;
    localparam logic [StepW-1:0] STEP_MINUS_TWO = 2'b10;
    localparam logic [StepW-1:0] STEP_MINUS_ONE = 2'b11;

    // Request tdata, lowest field last.
    typedef struct packed {
        logic [6:0]       fill;
        logic             armed;
        logic [MinW-1:0]  minute;
        logic [HourW-1:0] hour;
        logic [StepW-1:0] step_code;
        logic [ModeW-1:0] mode;
    } clock_request_t;

    // Result tdata, lowest field last.
    typedef struct packed {
        logic [2:0]       fill;
        logic             save_request;
        logic             alarm_match;
        logic [MinW-1:0]  edit_alarm_minute;
        logic [HourW-1:0] edit_alarm_hr;
        logic [MinW-1:0]  edit_minute;
        logic [HourW-1:0] edit_hour;
        logic             armed;
        logic [MinW-1:0]  alarm_minute;
        logic [HourW-1:0] alarm_hr;
        logic [MinW-1:0]  second;
        logic [MinW-1:0]  minute;
        logic [HourW-1:0] hour;
    } clock_report_t;

endpackage

// ===== sim/clock_report_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day clock result checker
// Watches the command and result streams and the rate register write port,
// keeps its own copy of the clock, alarm and edit buffers, and compares every
// result with the status predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module clock_report_checker
    import tdc_pkg::*;
    import tdc_tb_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [TickW-1:0]    cfg_wdata,
    input  wire logic                s_axis_tvalid,
    input  wire logic                s_axis_tready,
    // tdata, lowest bit up: mode, step, load_hour, load_minute, load_armed.
    input  wire logic [InDataW-1:0]  s_axis_tdata,
    // tuser: command.
    input  wire logic [CmdW-1:0]     s_axis_tuser,
    input  wire logic                m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // tdata, lowest bit up: hour, minute, second, alarm hour, alarm minute,
    // armed, edit hour, edit minute, alarm edit hour, alarm edit minute,
    // alarm match, save request.
    input  wire logic [OutDataW-1:0] m_axis_tdata,
    output int                       mismatches,
    output int                       outstanding
);

    localparam int ReportLimit = 10;

    logic [TickW-1:0] ticks_per_second;
    logic [TickW-1:0] prescale;
    logic [MinW-1:0]  seconds;
    logic [MinW-1:0]  minutes;
    logic [HourW-1:0] hours;
    logic [HourW-1:0] alarm_hr;
    logic [MinW-1:0]  alarm_minute;
    logic             armed;
    logic [HourW-1:0] edit_hour;
    logic [MinW-1:0]  edit_minute;
    logic [HourW-1:0] edit_alarm_hr;
    logic [MinW-1:0]  edit_alarm_minute;
    clock_report_t    awaited_reports[$];
    int               errors = 0;

    function automatic int roll(input int value, input int delta, input int modulus);
        return (value + delta + modulus) % modulus;
    endfunction

    function automatic clock_report_t predict_report(input logic [CmdW-1:0] cmd,
                                                     input clock_request_t req);
        clock_report_t  rep;
        logic [TickW:0] next_count;
        int             delta;
        logic           to_alarm;
        logic           to_hour;
        rep = '0;
        // The step field is two's complement, so 2'b10 means minus two.
        delta = req.step_code[StepW-1] ? int'(req.step_code) - 4 : int'(req.step_code);
        to_alarm = req.mode >= MODE_SET_AL_HR;
        to_hour = (req.mode == MODE_SET_HR) || (req.mode == MODE_SET_AL_HR);
        case (cmd)
            CMD_TICK: begin
                if (req.mode != MODE_SET_HR && req.mode != MODE_SET_MN) begin
                    next_count = {1'b0, prescale} + 1'b1;
                    if (next_count >= {1'b0, ticks_per_second}) begin
                        prescale = '0;
                        seconds = seconds + 1'b1;
                        if (seconds >= SecondsPerMinute) begin
                            seconds = '0;
                            minutes = minutes + 1'b1;
                            if (minutes >= MinutesPerHour) begin
                                minutes = '0;
                                hours = (hours + 1'b1) % HoursPerDay;
                            end
                        end
                    end else begin
                        prescale = next_count[TickW-1:0];
                    end
                end
            end
            CMD_BEGIN_TIME: begin
                edit_hour = hours;
                edit_minute = minutes;
            end
            CMD_COMMIT_TIME: begin
                hours = edit_hour;
                minutes = edit_minute;
                seconds = '0;
            end
            CMD_BEGIN_ALARM: begin
                edit_alarm_hr = alarm_hr;
                edit_alarm_minute = alarm_minute;
            end
            CMD_COMMIT_ALARM: begin
                alarm_hr = edit_alarm_hr;
                alarm_minute = edit_alarm_minute;
                armed = 1'b1;
            end
            CMD_ADJUST: begin
                if (to_alarm && to_hour) begin
                    edit_alarm_hr = HourW'(roll(int'(edit_alarm_hr), delta,
                                                int'(HoursPerDay)));
                end else if (to_alarm) begin
                    edit_alarm_minute = MinW'(roll(int'(edit_alarm_minute), delta,
                                                   int'(MinutesPerHour)));
                end else if (to_hour) begin
                    edit_hour = HourW'(roll(int'(edit_hour), delta, int'(HoursPerDay)));
                end else begin
                    edit_minute = MinW'(roll(int'(edit_minute), delta,
                                             int'(MinutesPerHour)));
                end
            end
            CMD_LOAD_ALARM: begin
                alarm_hr = req.hour;
                alarm_minute = req.minute;
                armed = req.armed;
            end
            default: begin
            end
        endcase
        rep.hour = hours;
        rep.minute = minutes;
        rep.second = seconds;
        rep.alarm_hr = alarm_hr;
        rep.alarm_minute = alarm_minute;
        rep.armed = armed;
        rep.edit_hour = edit_hour;
        rep.edit_minute = edit_minute;
        rep.edit_alarm_hr = edit_alarm_hr;
        rep.edit_alarm_minute = edit_alarm_minute;
        // The armed flag plays no part in the match.
        rep.alarm_match = (hours == alarm_hr) && (minutes == alarm_minute)
                        && (seconds == '0);
        rep.save_request = (cmd == CMD_COMMIT_ALARM);
        return rep;
    endfunction

    function automatic string show(input clock_report_t r);
        return $sformatf({"time %0d:%0d:%0d alarm %0d:%0d armed %0b edit %0d:%0d ",
                          "alarm edit %0d:%0d match %0b save %0b fill %0d"},
                         r.hour, r.minute, r.second, r.alarm_hr, r.alarm_minute,
                         r.armed, r.edit_hour, r.edit_minute, r.edit_alarm_hr,
                         r.edit_alarm_minute, r.alarm_match, r.save_request, r.fill);
    endfunction

    always @(posedge aclk) begin : monitor
        clock_report_t got;
        clock_report_t want;
        if (!aresetn) begin
            ticks_per_second = TicksPerSecondReset;
            prescale = '0;
            seconds = '0;
            minutes = '0;
            hours = '0;
            alarm_hr = '0;
            alarm_minute = '0;
            armed = 1'b0;
            edit_hour = '0;
            edit_minute = '0;
            edit_alarm_hr = '0;
            edit_alarm_minute = '0;
            awaited_reports.delete();
        end else begin
            // A result leaving at this edge belongs to an earlier request, so it
            // is matched before the request taken at the same edge is queued.
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (awaited_reports.size() == 0) begin
                    errors++;
                    if (errors <= ReportLimit) begin
                        $display("unexpected result: %s", show(got));
                    end
                end else begin
                    want = awaited_reports.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= ReportLimit) begin
                            $display("result mismatch: expected %s", show(want));
                            $display("                 actual   %s", show(got));
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_reports.push_back(predict_report(s_axis_tuser, s_axis_tdata));
            end
            if (cfg_we) begin
                ticks_per_second = cfg_wdata;
            end
        end
        outstanding <= awaited_reports.size();
        mismatches <= errors;
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day clock with alarm testbench
// Drives a short directed command list and then random phases of well-formed
// edit, load and tick sequences mixed with noise, each phase at its own rate
// setting, with random idling on both streams. A checker beside the design
// predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench
    import tdc_pkg::*;
    import tdc_tb_pkg::*;
();

    localparam int StallLimit = 1000;
    localparam int PhaseCount = 12;
    localparam int PhaseItems = 100;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [TickW-1:0]    cfg_wdata     = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata  = '0;
    logic [CmdW-1:0]     s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    int                  mismatches;
    int                  outstanding;

    bit                  calm        = 1'b0;
    int                  items_sent  = 0;
    clock_report_t       last_report = '0;

    always #5 aclk = ~aclk;

    time_of_day_clock_with_alarm dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    clock_report_checker report_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Ready is sampled at the falling edge, where it already holds the value
    // that the next rising edge will see.
    task automatic send(input logic [CmdW-1:0] cmd, input logic [ModeW-1:0] mode,
                        input logic [StepW-1:0] step_code, input logic [HourW-1:0] hr,
                        input logic [MinW-1:0] mn, input logic arm);
        clock_request_t req;
        int             gap;
        bit             taken;
        req = '0;
        req.mode = mode;
        req.step_code = step_code;
        req.hour = hr;
        req.minute = mn;
        req.armed = arm;
        gap = calm ? 0 : int'($urandom_range(0, 14));
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= req;
        s_axis_tuser <= cmd;
        do begin
            @(negedge aclk);
            taken = s_axis_tready;
            @(posedge aclk);
        end while (!taken);
        if (cmd != CMD_SPARE
                && !(cmd == CMD_TICK && (mode == MODE_SET_HR || mode == MODE_SET_MN))) begin
            items_sent++;
        end
    endtask

    // The fields that the command does not read carry random content.
    task automatic send_filled(input logic [CmdW-1:0] cmd, input logic [ModeW-1:0] mode);
        send(cmd, mode, StepW'($urandom_range(0, 3)), HourW'($urandom_range(0, 31)),
             MinW'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_any();
        send_filled(CmdW'($urandom_range(0, 7)), ModeW'($urandom_range(0, 7)));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_rate(input logic [TickW-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_ticks(input int count, input bit steady);
        logic [ModeW-1:0] mode;
        repeat (count) begin
            mode = (steady || $urandom_range(0, 4) != 0) ? MODE_NORMAL
                                                         : ModeW'($urandom_range(0, 7));
            send_filled(CMD_TICK, mode);
        end
    endtask

    task automatic edit_time();
        logic [ModeW-1:0] mode;
        send_filled(CMD_BEGIN_TIME, ModeW'($urandom_range(0, 7)));
        repeat ($urandom_range(1, 4)) begin
            mode = $urandom_range(0, 1) ? MODE_SET_HR : MODE_SET_MN;
            if ($urandom_range(0, 9) == 0) begin
                mode = ModeW'($urandom_range(0, 7));
            end
            send_filled(CMD_ADJUST, mode);
        end
        send_filled(CMD_COMMIT_TIME, ModeW'($urandom_range(0, 7)));
    endtask

    task automatic edit_alarm();
        logic [ModeW-1:0] mode;
        send_filled(CMD_BEGIN_ALARM, ModeW'($urandom_range(0, 7)));
        repeat ($urandom_range(1, 4)) begin
            mode = $urandom_range(0, 1) ? MODE_SET_AL_HR : MODE_SET_AL_MN;
            if ($urandom_range(0, 9) == 0) begin
                mode = ModeW'($urandom_range(0, 7));
            end
            send_filled(CMD_ADJUST, mode);
        end
        send_filled(CMD_COMMIT_ALARM, ModeW'($urandom_range(0, 7)));
    endtask

    // With nothing in flight the last result shows the live time, so the
    // alarm can be set to it; recommitting the time then clears the seconds
    // and the alarm matches.
    task automatic hit_alarm();
        drain();
        send(CMD_LOAD_ALARM, ModeW'($urandom_range(0, 7)), StepW'($urandom_range(0, 3)),
             last_report.hour, last_report.minute, 1'($urandom_range(0, 1)));
        send_filled(CMD_BEGIN_TIME, ModeW'($urandom_range(0, 7)));
        send_filled(CMD_COMMIT_TIME, ModeW'($urandom_range(0, 7)));
        run_ticks(int'($urandom_range(0, 3)), 1'b1);
    endtask

    task automatic load_alarm();
        if ($urandom_range(0, 4) == 0) begin
            send_filled(CMD_LOAD_ALARM, ModeW'($urandom_range(0, 7)));
        end else begin
            send(CMD_LOAD_ALARM, ModeW'($urandom_range(0, 7)), StepW'($urandom_range(0, 3)),
                 HourW'($urandom_range(0, 23)), MinW'($urandom_range(0, 59)),
                 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < StallLimit) begin
            @(posedge aclk);
            if (!aresetn || (s_axis_tvalid && s_axis_tready)
                    || (m_axis_tvalid && m_axis_tready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [TickW-1:0] rates [PhaseCount];
        int               pick;
        rates = '{16'd1, 16'd65535, 16'd3, 16'd1000, 16'd2, 16'd65535, 16'd1,
                  16'($urandom_range(1, 65535)), 16'd5, 16'd1, 16'd60, 16'd65535};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            forever begin : result_sink
                int stall;
                bit taken;
                stall = calm ? 0 : int'($urandom_range(0, 14));
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_axis_tready <= 1'b1;
                do begin
                    @(negedge aclk);
                    taken = m_axis_tvalid;
                    if (taken) begin
                        last_report = m_axis_tdata;
                    end
                    @(posedge aclk);
                end while (!taken);
            end
        join_none
        @(posedge aclk);

        // Directed part at the reset rate of 1000 ticks per second.
        send(CMD_TICK, MODE_NORMAL, STEP_ZERO, '0, '0, 1'b0);
        send(CMD_TICK, MODE_SET_HR, STEP_ZERO, '0, '0, 1'b0);
        send(CMD_TICK, MODE_SET_MN, STEP_ZERO, '0, '0, 1'b0);
        send(CMD_TICK, MODE_SPARE_7, STEP_ZERO, '0, '0, 1'b0);
        send(CMD_SPARE, MODE_NORMAL, STEP_PLUS_ONE, 5'd31, 6'd63, 1'b1);
        send(CMD_BEGIN_TIME, MODE_NORMAL, STEP_ZERO, '0, '0, 1'b0);
        send(CMD_ADJUST, MODE_SET_HR, STEP_MINUS_ONE, '0, '0, 1'b0);
        send(CMD_ADJUST, MODE_SET_MN, STEP_MINUS_ONE, '0, '0, 1'b0);
        send(CMD_ADJUST, MODE_NORMAL, STEP_PLUS_ONE, '0, '0, 1'b0);
        send(CMD_ADJUST, MODE_SPARE_6, STEP_MINUS_TWO, '0, '0, 1'b0);
        send(CMD_ADJUST, MODE_SET_HR, STEP_PLUS_ONE, '0, '0, 1'b0);
        send(CMD_ADJUST, MODE_SET_HR, STEP_MINUS_ONE, '0, '0, 1'b0);
        send(CMD_ADJUST, MODE_SET_MN, STEP_MINUS_ONE, '0, '0, 1'b0);
        send(CMD_COMMIT_TIME, MODE_NORMAL, STEP_ZERO, '0, '0, 1'b0);
        send(CMD_LOAD_ALARM, MODE_NORMAL, STEP_ZERO, 5'd23, 6'd59, 1'b0);
        // An alarm outside the valid range is stored as given.
        send(CMD_LOAD_ALARM, MODE_NORMAL, STEP_ZERO, 5'd31, 6'd63, 1'b1);
        send(CMD_BEGIN_ALARM, MODE_NORMAL, STEP_ZERO, '0, '0, 1'b0);
        send(CMD_ADJUST, MODE_SET_AL_HR, STEP_PLUS_ONE, '0, '0, 1'b0);
        send(CMD_ADJUST, MODE_SET_AL_MN, STEP_MINUS_TWO, '0, '0, 1'b0);
        send(CMD_ADJUST, MODE_SPARE_5, STEP_ZERO, '0, '0, 1'b0);
        send(CMD_ADJUST, MODE_SPARE_7, STEP_PLUS_ONE, '0, '0, 1'b0);
        send(CMD_COMMIT_ALARM, MODE_NORMAL, STEP_ZERO, '0, '0, 1'b0);
        send(CMD_LOAD_ALARM, MODE_NORMAL, STEP_ZERO, '0, '0, 1'b0);
        send(CMD_ADJUST, MODE_SET_AL_HR, STEP_MINUS_TWO, '0, '0, 1'b0);
        items_sent = 0;

        for (int phase = 0; phase < PhaseCount; phase++) begin
            drain();
            write_rate(rates[phase]);
            calm = (phase % 4 == 2);
            // The clock stands at 23:59:00 here, so one second per tick runs
            // it across midnight onto the alarm at 00:00.
            if (phase == 0) begin
                run_ticks(70, 1'b1);
            end
            while (items_sent < (phase + 1) * PhaseItems) begin
                pick = int'($urandom_range(0, 99));
                if (pick < 30) begin
                    run_ticks(int'($urandom_range(1, 20)), 1'b0);
                end else if (pick < 48) begin
                    edit_time();
                end else if (pick < 64) begin
                    edit_alarm();
                end else if (pick < 74) begin
                    hit_alarm();
                end else if (pick < 86) begin
                    load_alarm();
                end else begin
                    repeat ($urandom_range(1, 5)) send_any();
                end
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
